// File: rtl/tts_pkg.sv
`timescale 1ns / 1ps
// tts_pkg: shared types and constants for the tangent series pipeline
// used by tts_front, tts_slice and tangent_taylor_series; no dependencies

package tts_pkg;

    localparam int MAX_TERMS_DEF = 6;
    localparam int TERM_TABLE    = 6;

    localparam int ANGLE_W   = 16;
    localparam int TERMS_W   = 3;
    localparam int RAD_W     = 18;
    localparam int TAN_W     = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    localparam int MAG_W     = 15;
    localparam int A_W       = 17;
    localparam int FRAC_W    = 16;
    localparam int P_W       = 40;
    localparam int SUM_W     = 20;

    localparam int NUM_W     = 11;
    localparam int DEN_W     = 18;
    localparam int RECIP_W   = 25;
    localparam int RECIP_SH  = 24;
    localparam int PC_FULL_W = P_W + RECIP_W;
    localparam int PC_W      = 58;
    localparam int N_W       = 52;
    localparam int Q_W       = 18;
    localparam int LP_W      = 36;
    localparam int Q_SHIFT   = RECIP_SH + FRAC_W;
    localparam int RAD_FULL_W = 35;

    localparam logic signed [ANGLE_W-1:0] DEG_LIMIT   = 16'sd23040;
    localparam logic signed [RAD_W-1:0]   RAD_LIMIT   = 18'sd102944;
    localparam logic [18:0]               RAD_PER_DEG = 19'd292818;

    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic [A_W-1:0]     t_a;
    typedef logic [P_W-1:0]     t_pow;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [TERMS_W-1:0] t_terms;
    typedef logic [PC_W-1:0]    t_pc;
    typedef logic [N_W-1:0]     t_n;
    typedef logic [Q_W-1:0]     t_q;
    typedef logic [LP_W-1:0]    t_lp;

    // tangent number over odd factorial, reduced: t / f, and floor(t * 2^24 / f)
    localparam logic [NUM_W-1:0] TERM_NUM [TERM_TABLE] =
        '{11'd1, 11'd1, 11'd2, 11'd17, 11'd62, 11'd1382};
    localparam logic [DEN_W-1:0] TERM_DEN [TERM_TABLE] =
        '{18'd1, 18'd3, 18'd15, 18'd315, 18'd2835, 18'd155925};
    localparam logic [RECIP_W-1:0] TERM_RECIP [TERM_TABLE] =
        '{25'd16777216, 25'd5592405, 25'd2236962, 25'd905437, 25'd366909, 25'd148700};

    typedef struct packed {
        t_a     a;
        t_pow   p;
        t_sum   sum;
        logic   neg;
        t_terms terms;
    } t_slice_data;

endpackage

// File: rtl/tts_front.sv
`timescale 1ns / 1ps
// tts_front: angle clamp, magnitude and degree to radian conversion, two stages
// depends on tts_pkg

module tts_front #(
    parameter int MAX_TERMS = tts_pkg::MAX_TERMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [tts_pkg::ANGLE_W-1:0]  i_angle,
    input  tts_pkg::t_terms                     i_terms,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tts_pkg::t_slice_data                o_data
);

    logic                                r_v0;
    logic                                r_v1;
    tts_pkg::t_mag                       r_mag;
    logic                                r_neg0;
    tts_pkg::t_terms                     r_terms0;
    tts_pkg::t_slice_data                r_d1;
    logic                                w_en0;
    logic                                w_en1;
    logic signed [tts_pkg::ANGLE_W-1:0]  w_clamp;
    tts_pkg::t_mag                       n_mag;
    logic                                n_neg;
    tts_pkg::t_terms                     n_terms;
    logic [tts_pkg::RAD_FULL_W-1:0]      w_rad_full;
    tts_pkg::t_slice_data                n_d1;

    assign w_en1   = !r_v1 || i_ready;
    assign w_en0   = !r_v0 || w_en1;
    assign o_ready = w_en0;
    assign o_valid = r_v1;
    assign o_data  = r_d1;

    always_comb begin
        if (i_angle > tts_pkg::DEG_LIMIT) begin
            w_clamp = tts_pkg::DEG_LIMIT;
        end else if (i_angle < -tts_pkg::DEG_LIMIT) begin
            w_clamp = -tts_pkg::DEG_LIMIT;
        end else begin
            w_clamp = i_angle;
        end
        n_neg   = w_clamp[tts_pkg::ANGLE_W-1];
        n_mag   = tts_pkg::t_mag'(n_neg ? -w_clamp : w_clamp);
        n_terms = (i_terms > tts_pkg::t_terms'(MAX_TERMS)) ?
                  tts_pkg::t_terms'(MAX_TERMS) : i_terms;
    end

    // round half up on the magnitude
    assign w_rad_full = tts_pkg::RAD_FULL_W'(r_mag) * tts_pkg::RAD_FULL_W'(tts_pkg::RAD_PER_DEG)
                      + tts_pkg::RAD_FULL_W'(1 << (tts_pkg::FRAC_W - 1));

    always_comb begin
        n_d1       = '0;
        n_d1.a     = w_rad_full[tts_pkg::A_W+tts_pkg::FRAC_W-1:tts_pkg::FRAC_W];
        n_d1.p     = tts_pkg::t_pow'({n_d1.a, {tts_pkg::FRAC_W{1'b0}}});
        n_d1.neg   = r_neg0;
        n_d1.terms = r_terms0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_mag    <= n_mag;
            r_neg0   <= n_neg;
            r_terms0 <= n_terms;
        end
        if (w_en1) begin
            r_d1 <= n_d1;
        end
    end

endmodule

// File: rtl/tts_slice.sv
`timescale 1ns / 1ps
// tts_slice: one series term, two power steps (none for the first term),
// reciprocal multiply, exact floor correction and accumulation; depends on tts_pkg

module tts_slice #(
    parameter int K = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tts_pkg::t_slice_data i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tts_pkg::t_slice_data o_data
);

    logic                          w_av;
    tts_pkg::t_slice_data          w_ad;
    logic                          w_en_a;
    logic                          w_en_b;
    logic                          w_en_c;

    logic                          r_a_v;
    tts_pkg::t_slice_data          r_a_d;
    tts_pkg::t_pc                  r_a_pc;
    tts_pkg::t_n                   r_a_n;
    logic                          r_b_v;
    tts_pkg::t_slice_data          r_b_d;
    tts_pkg::t_q                   r_b_q1;
    tts_pkg::t_lp                  r_b_lp;
    tts_pkg::t_n                   r_b_n;
    logic                          r_c_v;
    tts_pkg::t_slice_data          r_c_d;

    logic [tts_pkg::PC_FULL_W-1:0] w_pc_full;
    tts_pkg::t_n                   n_a_n;
    tts_pkg::t_pc                  w_pc_rnd;
    tts_pkg::t_q                   n_b_q1;
    tts_pkg::t_lp                  n_b_lp;
    logic                          w_ge;
    tts_pkg::t_q                   w_term;
    tts_pkg::t_slice_data          n_c_d;

    assign w_en_c = !r_c_v || i_ready;
    assign w_en_b = !r_b_v || w_en_c;
    assign w_en_a = !r_a_v || w_en_b;

    generate
        if (K > 0) begin : g_pow
            logic                 r_pw_v [2];
            tts_pkg::t_slice_data r_pw_d [2];
            tts_pkg::t_slice_data n_pw_d [2];
            logic                 w_pw_en [2];
            logic [tts_pkg::P_W+tts_pkg::A_W-1:0] w_prod [2];

            assign w_pw_en[1] = !r_pw_v[1] || w_en_a;
            assign w_pw_en[0] = !r_pw_v[0] || w_pw_en[1];
            assign o_ready    = w_pw_en[0];
            assign w_av       = r_pw_v[1];
            assign w_ad       = r_pw_d[1];

            // p <- round(p * a / 2^16)
            always_comb begin
                w_prod[0]   = (tts_pkg::P_W+tts_pkg::A_W)'(i_data.p)
                            * (tts_pkg::P_W+tts_pkg::A_W)'(i_data.a)
                            + (tts_pkg::P_W+tts_pkg::A_W)'(1 << (tts_pkg::FRAC_W - 1));
                n_pw_d[0]   = i_data;
                n_pw_d[0].p = w_prod[0][tts_pkg::P_W+tts_pkg::FRAC_W-1:tts_pkg::FRAC_W];
                w_prod[1]   = (tts_pkg::P_W+tts_pkg::A_W)'(r_pw_d[0].p)
                            * (tts_pkg::P_W+tts_pkg::A_W)'(r_pw_d[0].a)
                            + (tts_pkg::P_W+tts_pkg::A_W)'(1 << (tts_pkg::FRAC_W - 1));
                n_pw_d[1]   = r_pw_d[0];
                n_pw_d[1].p = w_prod[1][tts_pkg::P_W+tts_pkg::FRAC_W-1:tts_pkg::FRAC_W];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pw_v[0] <= 1'b0;
                    r_pw_v[1] <= 1'b0;
                end else begin
                    if (w_pw_en[0]) begin
                        r_pw_v[0] <= i_valid;
                    end
                    if (w_pw_en[1]) begin
                        r_pw_v[1] <= r_pw_v[0];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_pw_en[0]) begin
                    r_pw_d[0] <= n_pw_d[0];
                end
                if (w_pw_en[1]) begin
                    r_pw_d[1] <= n_pw_d[1];
                end
            end
        end else begin : g_nopow
            assign o_ready = w_en_a;
            assign w_av    = i_valid;
            assign w_ad    = i_data;
        end
    endgenerate

    // candidate quotient from the reciprocal, exact numerator for the check
    assign w_pc_full = tts_pkg::PC_FULL_W'(w_ad.p)
                     * tts_pkg::PC_FULL_W'(tts_pkg::TERM_RECIP[K]);
    assign n_a_n     = tts_pkg::t_n'(w_ad.p) * tts_pkg::t_n'(tts_pkg::TERM_NUM[K])
                     + (tts_pkg::t_n'(tts_pkg::TERM_DEN[K]) << (tts_pkg::FRAC_W - 1));

    // candidate plus one, and its product with the denominator
    assign w_pc_rnd = r_a_pc + (tts_pkg::t_pc'(3) << (tts_pkg::Q_SHIFT - 1));
    assign n_b_q1   = w_pc_rnd[tts_pkg::Q_SHIFT+tts_pkg::Q_W-1:tts_pkg::Q_SHIFT];
    assign n_b_lp   = tts_pkg::t_lp'(n_b_q1) * tts_pkg::t_lp'(tts_pkg::TERM_DEN[K]);

    assign w_ge   = r_b_n >= {r_b_lp, {tts_pkg::FRAC_W{1'b0}}};
    assign w_term = w_ge ? r_b_q1 : r_b_q1 - tts_pkg::t_q'(1);

    always_comb begin
        n_c_d = r_b_d;
        if (tts_pkg::t_terms'(K) < r_b_d.terms) begin
            n_c_d.sum = r_b_d.sum + tts_pkg::t_sum'(w_term);
        end
    end

    assign o_valid = r_c_v;
    assign o_data  = r_c_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_v <= w_av;
            end
            if (w_en_b) begin
                r_b_v <= r_a_v;
            end
            if (w_en_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_d  <= w_ad;
            r_a_pc <= w_pc_full[tts_pkg::PC_W-1:0];
            r_a_n  <= n_a_n;
        end
        if (w_en_b) begin
            r_b_d  <= r_a_d;
            r_b_q1 <= n_b_q1;
            r_b_lp <= n_b_lp;
            r_b_n  <= r_a_n;
        end
        if (w_en_c) begin
            r_c_d <= n_c_d;
        end
    end

endmodule

// File: rtl/tangent_taylor_series.sv
`timescale 1ns / 1ps
// tangent_taylor_series: top level, front stage, one slice per series term, output register
// depends on tts_pkg, tts_front, tts_slice
//
//  channel   dir  tdata bits (lowest first)                     accepted when
//  s side    in   angle_degrees[15:0], term_count[18:16]         i_s_tvalid && o_s_tready
//  m side    out  angle_radians[17:0], tangent_value[49:18]      o_m_tvalid && i_m_tready
//
//  one item per cycle sustained while i_m_tready is high
//  path: front, per slice two power multiplies (none in the first) and three term stages
//  every stage has its own valid bit; a stage loads when empty or when the next one loads
//  reset (i_rst_n low, synchronous) clears all valid bits; no clearing pass

module tangent_taylor_series #(
    parameter int MAX_TERMS = tts_pkg::MAX_TERMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tts_pkg::S_TDATA_W-1:0]   i_s_tdata,   // angle_degrees, term_count
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tts_pkg::M_TDATA_W-1:0]   o_m_tdata    // angle_radians, tangent_value
);

    logic                         w_v [MAX_TERMS+1];
    logic                         w_r [MAX_TERMS+1];
    tts_pkg::t_slice_data         w_d [MAX_TERMS+1];
    logic                         w_en_o;
    logic                         r_ov;
    logic [tts_pkg::RAD_W-1:0]    r_rad;
    logic [tts_pkg::TAN_W-1:0]    r_tan;
    logic [tts_pkg::RAD_W-1:0]    n_rad;
    logic [tts_pkg::TAN_W-1:0]    n_tan;

    tts_front #(
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_angle (i_s_tdata[tts_pkg::ANGLE_W-1:0]),
        .i_terms (i_s_tdata[tts_pkg::ANGLE_W+tts_pkg::TERMS_W-1:tts_pkg::ANGLE_W]),
        .o_valid (w_v[0]),
        .i_ready (w_r[0]),
        .o_data  (w_d[0])
    );

    generate
        for (genvar k = 0; k < MAX_TERMS; k++) begin : g_slice
            tts_slice #(
                .K (k)
            ) u_slice (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_v[k]),
                .o_ready (w_r[k]),
                .i_data  (w_d[k]),
                .o_valid (w_v[k+1]),
                .i_ready (w_r[k+1]),
                .o_data  (w_d[k+1])
            );
        end
    endgenerate

    assign w_en_o          = !r_ov || i_m_tready;
    assign w_r[MAX_TERMS]  = w_en_o;

    // sum stays below 2^20, so it is widened and negated without saturation
    assign n_rad = w_d[MAX_TERMS].neg ?
                   -tts_pkg::RAD_W'(w_d[MAX_TERMS].a) : tts_pkg::RAD_W'(w_d[MAX_TERMS].a);
    assign n_tan = w_d[MAX_TERMS].neg ?
                   -tts_pkg::TAN_W'(w_d[MAX_TERMS].sum) : tts_pkg::TAN_W'(w_d[MAX_TERMS].sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_o) begin
            r_ov <= w_v[MAX_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_rad <= n_rad;
            r_tan <= n_tan;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(tts_pkg::M_TDATA_W-tts_pkg::TAN_W-tts_pkg::RAD_W){1'b0}}, r_tan, r_rad};

    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_tan[tts_pkg::TAN_W-1] |-> r_rad[tts_pkg::RAD_W-1])
        else $error("negative tangent for a non-negative angle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(r_rad) <= tts_pkg::RAD_LIMIT) &&
                       ($signed(r_rad) >= -tts_pkg::RAD_LIMIT))
        else $error("radians beyond the clamped range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_rad == '0) |-> (r_tan == '0))
        else $error("nonzero tangent at zero angle");

endmodule
